// File: hw/rtl/mac_pkg.sv
package mac_pkg;

	// Coefficient words per sensor: nine matrix terms, then x/y/z offsets
	localparam int COEFS = 12;
	localparam int MIN_SELECTED = 6;
	// Widest sensor index and coefficient slot carried between modules
	localparam int SN_W = 6;
	localparam int SLOT_W = 4;
	// First offset slot
	localparam logic [SLOT_W-1:0] SLOT_OFF = 4'd9;
	// Calc phase: reads issued on steps 0..CALC_READS-1, results settle by CALC_LAST
	localparam logic [3:0] CALC_READS = 4'd12;
	localparam logic [3:0] CALC_LAST = 4'd14;

	typedef enum logic [1:0] {
		OP_SAMPLE = 2'd0,
		OP_COEF   = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		STAT_STORED = 3'd0,
		STAT_FRAME  = 3'd1,
		STAT_BAD    = 3'd2,
		STAT_FEW    = 3'd3,
		STAT_DONE   = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_DECODE,
		S_CALC,
		S_STORE,
		S_RESULT,
		S_FR_RD,
		S_FR_OUT
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic in_take;
		logic init_we;
		logic [SN_W-1:0] init_row;
		logic [SLOT_W-1:0] mem_slot;
		logic coef_we;
		logic calc_rd;
		logic clr_mask;
		logic set_bit;
		logic st_we;
		logic [SN_W-1:0] frame_idx;
		logic out_load;
		status_t out_status;
		logic out_last;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		op_t op;
		logic bad_sensor;
		logic few;
		logic frame;
		logic out_free;
	} sts_t;

endpackage

// File: hw/rtl/mac_if.sv
// Input beat: one command or sample
interface mac_in_if;
	logic valid;
	logic ready;
	logic [1:0] op;
	logic [5:0] sensor;
	logic signed [15:0] axis_x;
	logic signed [15:0] axis_y;
	logic signed [15:0] axis_z;
	logic [3:0] coef_slot;
	logic signed [15:0] coef_value;

	modport source (
		output valid, op, sensor, axis_x, axis_y, axis_z, coef_slot, coef_value,
		input ready
	);
	modport sink (
		input valid, op, sensor, axis_x, axis_y, axis_z, coef_slot, coef_value,
		output ready
	);
endinterface

// Output beat: one result entry
interface mac_out_if;
	logic valid;
	logic ready;
	logic [2:0] status;
	logic [5:0] out_sensor;
	logic signed [17:0] out_x;
	logic signed [17:0] out_y;
	logic signed [17:0] out_z;
	logic last;

	modport source (
		output valid, status, out_sensor, out_x, out_y, out_z, last,
		input ready
	);
	modport sink (
		input valid, status, out_sensor, out_x, out_y, out_z, last,
		output ready
	);
endinterface

// File: hw/rtl/mac_dp.sv
module mac_dp import mac_pkg::*; #(
	parameter int SENSORS = 16
) (
	input logic clk,
	input logic arst_n,
	input cmd_t cmd,
	output sts_t sts,
	input logic [1:0] in_op,
	input logic [5:0] in_sensor,
	input logic signed [15:0] in_axis_x,
	input logic signed [15:0] in_axis_y,
	input logic signed [15:0] in_axis_z,
	input logic [3:0] in_coef_slot,
	input logic signed [15:0] in_coef_value,
	input logic cfg_we,
	input logic [15:0] cfg_wdata,
	input logic out_ready,
	output logic out_valid,
	output logic [2:0] out_status,
	output logic [5:0] out_sensor,
	output logic signed [17:0] out_x,
	output logic signed [17:0] out_y,
	output logic signed [17:0] out_z,
	output logic out_last
);

	localparam int SW = $clog2(SENSORS);
	localparam int DEPTH = SENSORS * COEFS;
	localparam int CAW = $clog2(DEPTH);
	localparam int SELW = (SENSORS < 16) ? SENSORS : 16;
	localparam logic [15:0] SEL_M = (SENSORS >= 16) ? 16'hFFFF : 16'((1 << SENSORS) - 1);
	localparam int PW = 33;
	localparam int AW = 35;
	localparam int FRAC = 14;
	localparam int QW = AW - FRAC;
	localparam logic signed [AW-1:0] RND_HALF = AW'(8192);
	localparam logic signed [QW-1:0] QMAX = QW'(131071);
	localparam logic signed [QW-1:0] QMIN = -QW'(131072);
	localparam logic signed [15:0] Q_ONE = 16'sd16384;

	// Identity row contents
	function automatic logic signed [15:0] init_value(input logic [SLOT_W-1:0] s);
		logic signed [15:0] v;
		case (s) inside
			4'd0, 4'd4, 4'd8: v = Q_ONE;
			default: v = '0;
		endcase
		return v;
	endfunction

	function automatic logic [1:0] slot_row(input logic [SLOT_W-1:0] s);
		logic [1:0] r;
		case (s) inside
			[4'd0:4'd2]: r = 2'd0;
			[4'd3:4'd5]: r = 2'd1;
			default: r = 2'd2;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] slot_col(input logic [SLOT_W-1:0] s);
		logic [1:0] c;
		case (s) inside
			4'd0, 4'd3, 4'd6: c = 2'd0;
			4'd1, 4'd4, 4'd7: c = 2'd1;
			default: c = 2'd2;
		endcase
		return c;
	endfunction

	// Captured input beat
	op_t op_q;
	logic [5:0] sn_q;
	logic signed [15:0] ax_q [3];
	logic [SLOT_W-1:0] coef_slot_q;
	logic signed [15:0] coef_val_q;

	// Config and mask state
	logic [15:0] sel_q;
	logic few_q;
	logic [SENSORS-1:0] upd_q;

	// Coefficient table
	logic signed [15:0] coef_mem [DEPTH];
	logic [SW-1:0] row;
	logic [SLOT_W-1:0] slot;
	logic [CAW-1:0] addr;
	logic mem_we;
	logic signed [15:0] mem_wdata;

	// Calc pipeline
	logic signed [15:0] coef_rd_s1;
	logic [SLOT_W-1:0] slot_s1;
	logic vld_s1;
	logic signed [16:0] d_q [3];
	logic signed [PW-1:0] prod_s2;
	logic [1:0] col_s2;
	logic [1:0] row_s2;
	logic vld_s2;
	logic signed [AW-1:0] acc_q;
	logic [1:0] row_s3;
	logic fin_s3;
	logic signed [17:0] r_q [3];
	logic [1:0] off_idx;
	logic signed [AW-1:0] rnd;
	logic signed [QW-1:0] qv;
	logic signed [17:0] sat;

	// Corrected store
	logic [53:0] st_mem [SENSORS];
	logic [SENSORS-1:0] st_vld_q;
	logic [53:0] st_rd_q;
	logic st_rd_vld_q;
	logic [SW-1:0] sw;
	logic [SW-1:0] fidx;

	// Mask logic
	logic [15:0] sel16;
	logic [2:0] nib [4];
	logic [4:0] sel_cnt;
	logic [SENSORS-1:0] sel_ext;
	logic [SENSORS-1:0] sn_hot;

	// Output register
	logic out_vld_q;
	logic [2:0] o_status;
	logic [5:0] o_sensor;
	logic signed [17:0] o_x;
	logic signed [17:0] o_y;
	logic signed [17:0] o_z;

	assign sw = sn_q[SW-1:0];
	assign fidx = cmd.frame_idx[SW-1:0];

	// Selected count over the bits that name real sensors
	always_comb begin
		sel16 = sel_q & SEL_M;
		for (int n = 0; n < 4; n++) begin
			nib[n] = 3'(sel16[4*n]) + 3'(sel16[4*n+1]) + 3'(sel16[4*n+2])
				+ 3'(sel16[4*n+3]);
		end
		sel_cnt = 5'(nib[0]) + 5'(nib[1]) + 5'(nib[2]) + 5'(nib[3]);
		sel_ext = '0;
		for (int i = 0; i < SELW; i++) begin
			sel_ext[i] = sel_q[i];
		end
		sn_hot = '0;
		sn_hot[sw] = 1'b1;
	end

	// Status to controller
	always_comb begin
		sts.op = op_q;
		sts.bad_sensor = {1'b0, sn_q} >= 7'(SENSORS);
		sts.few = few_q;
		sts.frame = (upd_q | sn_hot) == sel_ext;
		sts.out_free = !out_vld_q || out_ready;
	end

	// Table address and write source
	always_comb begin
		row = cmd.init_we ? cmd.init_row[SW-1:0] : sw;
		slot = cmd.coef_we ? coef_slot_q : cmd.mem_slot;
		addr = CAW'(row) * CAW'(COEFS) + CAW'(slot);
		mem_we = cmd.init_we || (cmd.coef_we && ({28'd0, coef_slot_q} < COEFS));
		mem_wdata = cmd.init_we ? init_value(cmd.mem_slot) : coef_val_q;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			coef_mem[addr] <= mem_wdata;
		end
		coef_rd_s1 <= coef_mem[addr];
	end

	// Rounding and saturation of a finished row
	always_comb begin
		rnd = acc_q + RND_HALF;
		qv = QW'(rnd >>> FRAC);
		if (qv > QMAX) begin
			sat = 18'sh1FFFF;
		end else if (qv < QMIN) begin
			sat = -18'sh20000;
		end else begin
			sat = 18'(qv);
		end
		off_idx = 2'(slot_s1 - SLOT_OFF);
	end

	// Input capture and calc datapath
	always_ff @(posedge clk) begin
		if (cmd.in_take) begin
			op_q <= op_t'(in_op);
			sn_q <= in_sensor;
			ax_q[0] <= in_axis_x;
			ax_q[1] <= in_axis_y;
			ax_q[2] <= in_axis_z;
			coef_slot_q <= in_coef_slot;
			coef_val_q <= in_coef_value;
		end
		slot_s1 <= cmd.mem_slot;
		if (vld_s1) begin
			if (slot_s1 >= SLOT_OFF) begin
				d_q[off_idx] <= 17'(ax_q[off_idx]) - 17'(coef_rd_s1);
			end else begin
				prod_s2 <= PW'(coef_rd_s1) * PW'(d_q[slot_col(slot_s1)]);
				col_s2 <= slot_col(slot_s1);
				row_s2 <= slot_row(slot_s1);
			end
		end
		if (vld_s2) begin
			acc_q <= ((col_s2 == 2'd0) ? '0 : acc_q) + AW'(prod_s2);
		end
		row_s3 <= row_s2;
		if (fin_s3) begin
			r_q[row_s3] <= sat;
		end
	end

	// Corrected store, read one entry per cycle at the frame walk index
	always_ff @(posedge clk) begin
		if (cmd.st_we) begin
			st_mem[sw] <= {r_q[0], r_q[1], r_q[2]};
		end
		st_rd_q <= st_mem[fidx];
	end

	// Result payload
	always_comb begin
		o_status = cmd.out_status;
		o_sensor = '0;
		o_x = '0;
		o_y = '0;
		o_z = '0;
		case (cmd.out_status)
			STAT_STORED, STAT_FEW: begin
				o_sensor = sn_q;
				o_x = r_q[0];
				o_y = r_q[1];
				o_z = r_q[2];
			end
			STAT_FRAME: begin
				o_sensor = cmd.frame_idx;
				if (st_rd_vld_q) begin
					o_x = st_rd_q[53:36];
					o_y = st_rd_q[35:18];
					o_z = st_rd_q[17:0];
				end
			end
			default: begin
				o_sensor = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_status <= o_status;
			out_sensor <= o_sensor;
			out_x <= o_x;
			out_y <= o_y;
			out_z <= o_z;
			out_last <= cmd.out_last;
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= '0;
			few_q <= 1'b1;
			upd_q <= '0;
			st_vld_q <= '0;
			st_rd_vld_q <= 1'b0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			fin_s3 <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				sel_q <= cfg_wdata;
			end
			few_q <= sel_cnt < 5'(MIN_SELECTED);
			if (cmd.clr_mask) begin
				upd_q <= '0;
			end else if (cmd.set_bit) begin
				upd_q <= upd_q | sn_hot;
			end
			if (cmd.st_we) begin
				st_vld_q[sw] <= 1'b1;
			end
			st_rd_vld_q <= st_vld_q[fidx];
			vld_s1 <= cmd.calc_rd;
			vld_s2 <= vld_s1 && (slot_s1 < SLOT_OFF);
			fin_s3 <= vld_s2 && (col_s2 == 2'd2);
			if (cmd.out_load) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_vld_q;

`ifndef SYNTHESIS
	// Calc pipeline has drained when the row results are stored
	a_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.st_we |-> (!vld_s1 && !vld_s2 && !fin_s3))
		else $error("store written while calc pipeline busy");

	// A sensor bit is only recorded when enough sensors are selected
	a_no_set_few: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.set_bit |-> !few_q)
		else $error("updated mask set with too few sensors selected");

	// Frame entries only go out while the mask matches the selection
	a_frame_match: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load && (cmd.out_status == STAT_FRAME)) |-> (upd_q == sel_ext))
		else $error("frame entry with incomplete mask");
`endif

endmodule

// File: hw/rtl/mac_ctrl.sv
module mac_ctrl import mac_pkg::*; #(
	parameter int SENSORS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input sts_t sts,
	output cmd_t cmd
);

	localparam int SW = $clog2(SENSORS);
	localparam logic [SW-1:0] LAST_SN = SW'(SENSORS - 1);
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(COEFS - 1);

	// Calc step to table slot: offsets first, then matrix row-major
	function automatic logic [SLOT_W-1:0] step_slot(input logic [3:0] st);
		logic [SLOT_W-1:0] s;
		if (st < 4'd3) begin
			s = st + SLOT_OFF;
		end else begin
			s = st - 4'd3;
		end
		return s;
	endfunction

	state_t state_q;
	state_t state_d;
	logic [SW-1:0] init_row_q;
	logic [SLOT_W-1:0] init_slot_q;
	logic [3:0] step_q;
	logic [SW-1:0] frame_q;
	status_t res_q;
	status_t res_dec;
	logic in_take;

	assign in_take = in_valid && (state_q == S_IDLE);

	// Result code for a command decided at decode
	always_comb begin
		case (sts.op)
			OP_CLEAR, OP_NONE: res_dec = STAT_DONE;
			default: res_dec = sts.bad_sensor ? STAT_BAD : STAT_DONE;
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_INIT: begin
				if ((init_row_q == LAST_SN) && (init_slot_q == LAST_SLOT)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				if ((sts.op == OP_SAMPLE) && !sts.bad_sensor) begin
					state_d = S_CALC;
				end else begin
					state_d = S_RESULT;
				end
			end
			S_CALC: begin
				if (step_q == CALC_LAST) begin
					state_d = S_STORE;
				end
			end
			S_STORE: begin
				if (!sts.few && sts.frame) begin
					state_d = S_FR_RD;
				end else begin
					state_d = S_RESULT;
				end
			end
			S_RESULT: begin
				if (sts.out_free) begin
					state_d = S_IDLE;
				end
			end
			S_FR_RD: begin
				state_d = S_FR_OUT;
			end
			S_FR_OUT: begin
				if (sts.out_free) begin
					state_d = (frame_q == LAST_SN) ? S_IDLE : S_FR_RD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Commands
	always_comb begin
		in_ready = (state_q == S_IDLE);
		cmd.in_take = in_take;
		cmd.init_we = (state_q == S_INIT);
		cmd.init_row = SN_W'(init_row_q);
		cmd.mem_slot = (state_q == S_INIT) ? init_slot_q : step_slot(step_q);
		cmd.coef_we = (state_q == S_DECODE) && (sts.op == OP_COEF) && !sts.bad_sensor;
		cmd.calc_rd = (state_q == S_CALC) && (step_q < CALC_READS);
		cmd.clr_mask = (state_q == S_DECODE) && (sts.op == OP_CLEAR);
		cmd.set_bit = (state_q == S_STORE) && !sts.few;
		cmd.st_we = (state_q == S_STORE);
		cmd.frame_idx = SN_W'(frame_q);
		cmd.out_load = ((state_q == S_RESULT) || (state_q == S_FR_OUT)) && sts.out_free;
		cmd.out_status = (state_q == S_FR_OUT) ? STAT_FRAME : res_q;
		cmd.out_last = (state_q == S_RESULT) || (frame_q == LAST_SN);
	end

	// State and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			init_row_q <= '0;
			init_slot_q <= '0;
			step_q <= '0;
			frame_q <= '0;
			res_q <= STAT_DONE;
		end else begin
			state_q <= state_d;
			if (state_q == S_INIT) begin
				if (init_slot_q == LAST_SLOT) begin
					init_slot_q <= '0;
					init_row_q <= init_row_q + 1'b1;
				end else begin
					init_slot_q <= init_slot_q + 1'b1;
				end
			end
			if (state_q == S_DECODE) begin
				step_q <= '0;
				res_q <= res_dec;
			end else if (state_q == S_CALC) begin
				step_q <= step_q + 1'b1;
			end
			if (state_q == S_STORE) begin
				frame_q <= '0;
				res_q <= sts.few ? STAT_FEW : STAT_STORED;
			end else if ((state_q == S_FR_OUT) && sts.out_free) begin
				frame_q <= frame_q + 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	// An accepted beat is decoded on the next cycle
	a_take_decode: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> (state_q == S_DECODE))
		else $error("accepted beat not decoded");

	// Calc step never runs past its settle point
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CALC) |-> (step_q <= CALC_LAST))
		else $error("calc step overrun");

	// Frame walk only starts from the store step
	a_frame_entry: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_FR_RD) && (frame_q == '0)) |-> ($past(state_q) == S_STORE))
		else $error("frame walk entered out of order");
`endif

endmodule

// File: hw/rtl/magnetometer_array_calibrate_frame_unit.sv
// Channel  | Dir | Handshake     | Beat
// ---------+-----+---------------+-------------------------------------------
// in_ch    | in  | valid/ready   | op, sensor, axis_x/y/z, coef_slot/value
// out_ch   | out | valid/ready   | status, out_sensor, out_x/y/z, last
// cfg      | in  | cfg_we        | cfg_wdata -> selected_mask
//
// A sample passes through accept, decode, calc (12 table reads: three offsets, then nine
// matrix terms through one shared multiplier and accumulator), store and result load.
// A complete frame replaces the result load with a store read and a load per sensor.
// Commands (coefficient write, frame consumed, bad index) pass through accept, decode
// and result load. After reset the table is loaded with identity rows for every sensor,
// with in_ch.ready low. One output register decouples stalls.
module magnetometer_array_calibrate_frame_unit import mac_pkg::*; #(
	parameter int SENSORS = 16
) (
	input logic clk,
	input logic arst_n,
	mac_in_if.sink in_ch,
	mac_out_if.source out_ch,
	input logic cfg_we,
	input logic [15:0] cfg_wdata
);

	cmd_t cmd;
	sts_t sts;

	// Sequencer
	mac_ctrl #(
		.SENSORS(SENSORS)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_ch.valid),
		.in_ready(in_ch.ready),
		.sts(sts),
		.cmd(cmd)
	);

	// Table, arithmetic, stores and output register
	mac_dp #(
		.SENSORS(SENSORS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.in_op(in_ch.op),
		.in_sensor(in_ch.sensor),
		.in_axis_x(in_ch.axis_x),
		.in_axis_y(in_ch.axis_y),
		.in_axis_z(in_ch.axis_z),
		.in_coef_slot(in_ch.coef_slot),
		.in_coef_value(in_ch.coef_value),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.out_ready(out_ch.ready),
		.out_valid(out_ch.valid),
		.out_status(out_ch.status),
		.out_sensor(out_ch.out_sensor),
		.out_x(out_ch.out_x),
		.out_y(out_ch.out_y),
		.out_z(out_ch.out_z),
		.out_last(out_ch.last)
	);

endmodule

// File: test/tb_magnetometer_array_calibrate_frame_unit.sv
module tb_magnetometer_array_calibrate_frame_unit import mac_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_SENS = 16;
	localparam int SETTLE_CYCLES = 8;
	localparam int TAIL_CYCLES = 40;
	// Directed row kinds and the marker for rows left to the predictor
	localparam int ROW_BEAT = 0;
	localparam int ROW_MASK = 1;
	localparam int PREDICT = -1;

	typedef struct packed {
		op_t op;
		logic [5:0] sensor;
		logic signed [15:0] ax;
		logic signed [15:0] ay;
		logic signed [15:0] az;
		logic [3:0] slot;
		logic signed [15:0] value;
	} cmd_beat_t;

	typedef struct packed {
		status_t status;
		logic [5:0] sensor;
		logic signed [17:0] x;
		logic signed [17:0] y;
		logic signed [17:0] z;
		logic last;
	} entry_t;

	typedef struct {
		int kind;
		int op;
		int sn;
		int x;
		int y;
		int z;
		int slot;
		int val;
		int e_st;
		int e_sn;
		int e_x;
		int e_y;
		int e_z;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic [15:0] cfg_wdata;
	logic hold_rx = 1'b0;
	int gap_pct = 24;
	int stall_pct = 45;
	int beats_sent = 0;
	int entries_seen = 0;
	int fails = 0;

	// Shadow of the calibration state
	logic signed [15:0] cal_coef [N_SENS][COEFS];
	logic signed [17:0] cal_store [N_SENS][3];
	logic [15:0] seen_mask;
	logic [15:0] want_mask;
	entry_t due [$];

	mac_in_if in_ch ();
	mac_out_if out_ch ();

	magnetometer_array_calibrate_frame_unit #(
		.SENSORS(N_SENS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// Directed stimulus; typed expectations only where they are obvious
	dir_row_t dir_rows [27] = '{
		'{ROW_MASK, OP_NONE,    0,      0,      0,      0,  0, 'h001F, PREDICT, 0, 0, 0, 0},
		// fewer than six selected: identity rows pass the sample through
		'{ROW_BEAT, OP_SAMPLE,  0,  32767, -32768,      0,  0,      0,
			STAT_FEW,  0, 32767, -32768,      0},
		'{ROW_BEAT, OP_SAMPLE, 15,     -1,      1, -32768, 15,     -1,
			STAT_FEW, 15,    -1,      1, -32768},
		// sensor index out of range
		'{ROW_BEAT, OP_SAMPLE, 16,   1234,      5,      6,  0,      0, STAT_BAD, 0, 0, 0, 0},
		'{ROW_BEAT, OP_SAMPLE, 63, -32768,  32767,  32767,  0,      0, STAT_BAD, 0, 0, 0, 0},
		'{ROW_BEAT, OP_COEF,   63,      0,      0,      0,  0,    100, STAT_BAD, 0, 0, 0, 0},
		// slots above the offsets are dropped
		'{ROW_BEAT, OP_COEF,    5,      0,      0,      0, 12,  32767, STAT_DONE, 0, 0, 0, 0},
		'{ROW_BEAT, OP_COEF,    5,      0,      0,      0, 15, -32768, STAT_DONE, 0, 0, 0, 0},
		'{ROW_BEAT, OP_NONE,   63,  32767,  32767,  32767, 15,     -1, STAT_DONE, 0, 0, 0, 0},
		'{ROW_BEAT, OP_CLEAR,   0,      0,      0,      0,  0,      0, STAT_DONE, 0, 0, 0, 0},
		// sensor 1 gets extreme matrix terms (row-major) and offsets
		'{ROW_BEAT, OP_COEF,    1,      0,      0,      0,  0,  32767, STAT_DONE, 0, 0, 0, 0},
		'{ROW_BEAT, OP_COEF,    1,      0,      0,      0,  4, -32768, STAT_DONE, 0, 0, 0, 0},
		'{ROW_BEAT, OP_COEF,    1,      0,      0,      0,  8,  32767, STAT_DONE, 0, 0, 0, 0},
		'{ROW_BEAT, OP_COEF,    1,      0,      0,      0,  1, -32768, STAT_DONE, 0, 0, 0, 0},
		'{ROW_BEAT, OP_COEF,    1,      0,      0,      0, SLOT_OFF, -32768,
			STAT_DONE, 0, 0, 0, 0},
		'{ROW_BEAT, OP_COEF,    1,      0,      0,      0, SLOT_OFF + 1, 32767,
			STAT_DONE, 0, 0, 0, 0},
		'{ROW_BEAT, OP_SAMPLE,  1,  32767, -32768, -32768,  0,      0, PREDICT, 0, 0, 0, 0},
		'{ROW_BEAT, OP_SAMPLE,  1, -32768,  32767,  32767,  0,      0, PREDICT, 0, 0, 0, 0},
		// exactly six selected: the sixth sample completes the frame
		'{ROW_MASK, OP_NONE,    0,      0,      0,      0,  0, 'h003F, PREDICT, 0, 0, 0, 0},
		'{ROW_BEAT, OP_SAMPLE,  0,    100,   -200,    300,  0,      0, PREDICT, 0, 0, 0, 0},
		'{ROW_BEAT, OP_SAMPLE,  1,     -5,      7,      9,  0,      0, PREDICT, 0, 0, 0, 0},
		'{ROW_BEAT, OP_SAMPLE,  2,      0,      0,      0,  0,      0, PREDICT, 0, 0, 0, 0},
		'{ROW_BEAT, OP_SAMPLE,  3,  32767,  32767,  32767,  0,      0, PREDICT, 0, 0, 0, 0},
		'{ROW_BEAT, OP_SAMPLE,  4, -32768, -32768, -32768,  0,      0, PREDICT, 0, 0, 0, 0},
		'{ROW_BEAT, OP_SAMPLE,  5,     12,     34,     56,  0,      0, PREDICT, 0, 0, 0, 0},
		// mask not cleared: frame goes out again
		'{ROW_BEAT, OP_SAMPLE,  5,      1,      2,      3,  0,      0, PREDICT, 0, 0, 0, 0},
		'{ROW_BEAT, OP_CLEAR,   0,      0,      0,      0,  0,      0, STAT_DONE, 0, 0, 0, 0}
	};

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Expected entries for one accepted beat
	function automatic void calibrate_beat(input cmd_beat_t b);
		entry_t e;
		longint raw [3];
		longint diff [3];
		longint acc;
		logic signed [17:0] fix [3];
		int sn;
		e = '0;
		e.last = 1'b1;
		sn = int'(b.sensor);
		raw[0] = longint'(b.ax);
		raw[1] = longint'(b.ay);
		raw[2] = longint'(b.az);
		if (b.op == OP_CLEAR || b.op == OP_NONE) begin
			if (b.op == OP_CLEAR)
				seen_mask = '0;
			e.status = STAT_DONE;
		end else if (sn >= N_SENS) begin
			e.status = STAT_BAD;
		end else if (b.op == OP_COEF) begin
			if (b.slot < COEFS)
				cal_coef[sn][b.slot] = b.value;
			e.status = STAT_DONE;
		end else begin
			// M * (s - c), Q2.14 rounded half up, saturated to 18 bits
			for (int i = 0; i < 3; i++)
				diff[i] = raw[i] - longint'(cal_coef[sn][SLOT_OFF + i]);
			for (int i = 0; i < 3; i++) begin
				acc = 0;
				for (int j = 0; j < 3; j++)
					acc += longint'(cal_coef[sn][3 * i + j]) * diff[j];
				acc = (acc + 8192) >>> 14;
				if (acc > 131071)
					acc = 131071;
				else if (acc < -131072)
					acc = -131072;
				fix[i] = 18'(acc);
				cal_store[sn][i] = fix[i];
			end
			e.sensor = b.sensor;
			e.x = fix[0];
			e.y = fix[1];
			e.z = fix[2];
			if ($countones(want_mask) < MIN_SELECTED) begin
				e.status = STAT_FEW;
			end else begin
				seen_mask[sn] = 1'b1;
				if (seen_mask != want_mask) begin
					e.status = STAT_STORED;
				end else begin
					for (int k = 0; k < N_SENS; k++) begin
						e.status = STAT_FRAME;
						e.sensor = 6'(k);
						e.x = cal_store[k][0];
						e.y = cal_store[k][1];
						e.z = cal_store[k][2];
						e.last = (k == N_SENS - 1);
						due.push_back(e);
					end
					return;
				end
			end
		end
		due.push_back(e);
	endfunction

	function automatic cmd_beat_t rand_beat();
		cmd_beat_t b;
		b.op = op_t'(2'($urandom_range(3)));
		b.sensor = 6'($urandom);
		b.ax = 16'($urandom);
		b.ay = 16'($urandom);
		b.az = 16'($urandom);
		b.slot = 4'($urandom);
		b.value = 16'($urandom);
		return b;
	endfunction

	// Coefficient within +-1.0 so most outputs stay out of saturation
	function automatic logic signed [15:0] mild_value();
		return 16'($urandom_range(32767) - 16384);
	endfunction

	function automatic logic [15:0] rand_mask(input int min_bits);
		logic [15:0] m;
		do
			m = 16'($urandom);
		while ($countones(m) < min_bits);
		return m;
	endfunction

	// Offer one beat; valid stays up after acceptance unless the next call idles
	task automatic push_beat(input cmd_beat_t b);
		while ($urandom_range(99) < gap_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.op <= b.op;
		in_ch.sensor <= b.sensor;
		in_ch.axis_x <= b.ax;
		in_ch.axis_y <= b.ay;
		in_ch.axis_z <= b.az;
		in_ch.coef_slot <= b.slot;
		in_ch.coef_value <= b.value;
		do
			@(posedge clk);
		while (in_ch.ready !== 1'b1);
		beats_sent++;
		calibrate_beat(b);
	endtask

	task automatic settle();
		in_ch.valid <= 1'b0;
		while (due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_mask(input logic [15:0] m);
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
		want_mask = m;
	endtask

	task automatic stall_output(input int cycles);
		hold_rx <= 1'b1;
		repeat (cycles) @(posedge clk);
		hold_rx <= 1'b0;
	endtask

	// Each selected sensor once in random order (a random one if none), with stray beats, then frame consumed
	task automatic frame_round();
		int order [$];
		int j;
		int t;
		cmd_beat_t b;
		for (int k = 0; k < N_SENS; k++)
			if (want_mask[k])
				order.push_back(k);
		for (int k = order.size() - 1; k > 0; k--) begin
			j = $urandom_range(k);
			t = order[k];
			order[k] = order[j];
			order[j] = t;
		end
		if (order.size() == 0)
			order.push_back($urandom_range(N_SENS - 1));
		foreach (order[n]) begin
			if ($urandom_range(99) < 20) begin
				b = rand_beat();
				b.op = OP_COEF;
				b.sensor = 6'(order[n]);
				b.slot = 4'($urandom_range(COEFS - 1));
				b.value = mild_value();
				push_beat(b);
			end
			if ($urandom_range(99) < 15) begin
				b = rand_beat();
				b.op = OP_SAMPLE;
				b.sensor = 6'($urandom_range(N_SENS - 1));
				push_beat(b);
			end
			b = rand_beat();
			b.op = OP_SAMPLE;
			b.sensor = 6'(order[n]);
			push_beat(b);
		end
		// sometimes resample before consuming, so the frame repeats
		if ($urandom_range(99) < 30) begin
			b = rand_beat();
			b.op = OP_SAMPLE;
			b.sensor = 6'(order[0]);
			push_beat(b);
		end
		b = rand_beat();
		b.op = OP_CLEAR;
		push_beat(b);
	endtask

	task automatic random_traffic(input int budget);
		int stop;
		cmd_beat_t b;
		stop = beats_sent + budget;
		while (beats_sent < stop) begin
			if ($urandom_range(99) < 70) begin
				frame_round();
			end else begin
				b = rand_beat();
				if ($urandom_range(1) == 1)
					b.sensor = 6'($urandom_range(N_SENS - 1));
				if (b.op == OP_COEF && $urandom_range(99) < 70)
					b.value = mild_value();
				push_beat(b);
			end
		end
	endtask

	task automatic run_phase(input logic [15:0] m, input int tx, input int rx,
			input int budget, input int hold_cycles);
		settle();
		write_mask(m);
		gap_pct = tx;
		stall_pct = rx;
		if (hold_cycles > 0) begin
			fork
				stall_output(hold_cycles);
				random_traffic(budget);
			join
		end else begin
			random_traffic(budget);
		end
	endtask

	// Output ready with random stalls, or held low during a hold-off
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			out_ch.ready <= !hold_rx && ($urandom_range(99) >= stall_pct);
		end
	end

	// Result checker: each beat against the oldest expected entry
	always @(posedge clk) begin
		entry_t got;
		entry_t want;
		if (arst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			got.status = status_t'(out_ch.status);
			got.sensor = out_ch.out_sensor;
			got.x = out_ch.out_x;
			got.y = out_ch.out_y;
			got.z = out_ch.out_z;
			got.last = out_ch.last;
			if (due.size() == 0) begin
				if (fails < 10)
					$display("result %0d unexpected: st=%0d sn=%0d x=%0d y=%0d z=%0d l=%0b",
						entries_seen, got.status, got.sensor, got.x, got.y, got.z, got.last);
				fails++;
			end else begin
				want = due.pop_front();
				if (got.status !== want.status || got.sensor !== want.sensor ||
						got.x !== want.x || got.y !== want.y || got.z !== want.z ||
						got.last !== want.last) begin
					if (fails < 10) begin
						$display("result %0d want: st=%0d sn=%0d x=%0d y=%0d z=%0d l=%0b",
							entries_seen, want.status, want.sensor, want.x, want.y, want.z,
							want.last);
						$display("result %0d got:  st=%0d sn=%0d x=%0d y=%0d z=%0d l=%0b",
							entries_seen, got.status, got.sensor, got.x, got.y, got.z, got.last);
					end
					fails++;
				end
			end
			entries_seen++;
		end
	end

	initial begin
		#1000000;
		$display("FAIL");
		$finish;
	end

	initial begin
		dir_row_t r;
		cmd_beat_t b;
		entry_t e;
		in_ch.valid = 1'b0;
		in_ch.op = OP_SAMPLE;
		in_ch.sensor = '0;
		in_ch.axis_x = '0;
		in_ch.axis_y = '0;
		in_ch.axis_z = '0;
		in_ch.coef_slot = '0;
		in_ch.coef_value = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		// reset state: identity matrices, zero offsets, empty store
		for (int s = 0; s < N_SENS; s++) begin
			for (int c = 0; c < COEFS; c++)
				cal_coef[s][c] = '0;
			cal_coef[s][0] = 16'sd16384;
			cal_coef[s][4] = 16'sd16384;
			cal_coef[s][8] = 16'sd16384;
			for (int a = 0; a < 3; a++)
				cal_store[s][a] = '0;
		end
		seen_mask = '0;
		want_mask = '0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part
		foreach (dir_rows[i]) begin
			r = dir_rows[i];
			if (r.kind == ROW_MASK) begin
				settle();
				write_mask(16'(r.val));
			end else begin
				b.op = op_t'(2'(r.op));
				b.sensor = 6'(r.sn);
				b.ax = 16'(r.x);
				b.ay = 16'(r.y);
				b.az = 16'(r.z);
				b.slot = 4'(r.slot);
				b.value = 16'(r.val);
				push_beat(b);
				// typed rows are single-entry: swap in the hand-written expectation
				if (r.e_st != PREDICT) begin
					e.status = status_t'(3'(r.e_st));
					e.sensor = 6'(r.e_sn);
					e.x = 18'(r.e_x);
					e.y = 18'(r.e_y);
					e.z = 18'(r.e_z);
					e.last = 1'b1;
					void'(due.pop_back());
					due.push_back(e);
				end
			end
		end

		// Random part: receiver-heavy stalls, then sender-heavy idling, then none
		run_phase(16'hFFFF, 24, 45, 8, 0);
		run_phase(16'h003F, 24, 45, 8, 0);
		run_phase(rand_mask(MIN_SELECTED), 45, 24, 8, 300);
		run_phase(16'h0000, 45, 24, 6, 0);
		run_phase(rand_mask(0), 0, 0, 8, 0);
		run_phase(rand_mask(MIN_SELECTED), 0, 0, 8, 0);

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fails == 0 && due.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
